@@ rtl/core/fdp_pkg.sv @@
package fdp_pkg;

   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 14;
   localparam int SERIAL_W = 22;
   localparam int SUM_W    = 24;
   localparam int QUOT_W   = 8;
   localparam int PROD_W   = YEAR_W + 13;

   localparam logic [SERIAL_W-1:0] SERIAL_MAX    = 22'h3FFFFF;
   localparam logic [SUM_W-1:0]    DAYS_PER_YEAR = 24'd365;
   localparam logic [YEAR_W-1:0]   CENTURY       = 14'd100;
   // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
   localparam logic [12:0]         RECIP_100     = 13'd5243;
   localparam int                  RECIP_SHIFT   = 19;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } fdp_date_type;

   typedef struct packed {
      fdp_date_type        date;
      logic [SERIAL_W-1:0] serial;
      logic                last;
   } fdp_item_type;

   typedef struct packed {
      fdp_date_type        first;
      fdp_date_type        second;
      logic [SERIAL_W-1:0] distance;
   } fdp_result_type;

   // days in the months before this one, non-leap; months past twelve count as december
   function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] month);
      logic [8:0] d;
      case (month)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd334;
      endcase
      return d;
   endfunction

endpackage

@@ rtl/core/fdp_front.sv @@
module fdp_front
   import fdp_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   localparam int LW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [DAY_W-1:0]    req_day,
   input  logic [MONTH_W-1:0]  req_month,
   input  logic [YEAR_W-1:0]   req_year,
   input  logic                req_last,
   input  logic [LW-1:0]       queue_level,
   output logic                item_push,
   output fdp_item_type        item
);

   logic                s1_valid_ff, s1_valid_in;
   fdp_date_type        s1_date_ff;
   logic                s1_last_ff;
   logic [YEAR_W-1:0]   s1_y1_ff;
   logic [QUOT_W-1:0]   s1_qy1_ff;
   logic [QUOT_W-1:0]   s1_qyr_ff;
   logic [YEAR_W-1:0]   y1;
   logic [PROD_W-1:0]   prod_y1, prod_yr;

   logic                s2_valid_ff;
   fdp_item_type        s2_item_ff, s2_item_in;

   logic [LW:0]         occupancy;
   logic                leap;
   logic                rem_zero;
   logic [SUM_W-1:0]    sum;

   // credit check: queue plus everything in flight must fit
   assign occupancy   = {1'b0, queue_level} + (LW+1)'(s1_valid_ff) + (LW+1)'(s2_valid_ff);
   assign req_full    = occupancy >= (LW+1)'(QUEUE_DEPTH);
   assign s1_valid_in = req_push && !req_full;

   // stage 1: preceding year and the two divisions by a hundred
   assign y1      = (req_year == '0) ? '0 : req_year - YEAR_W'(1);
   assign prod_y1 = PROD_W'(y1) * PROD_W'(RECIP_100);
   assign prod_yr = PROD_W'(req_year) * PROD_W'(RECIP_100);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_date_ff <= '{year: req_year, month: req_month, day: req_day};
      s1_last_ff <= req_last;
      s1_y1_ff   <= y1;
      s1_qy1_ff  <= prod_y1[RECIP_SHIFT +: QUOT_W];
      s1_qyr_ff  <= prod_yr[RECIP_SHIFT +: QUOT_W];
      s2_item_ff <= s2_item_in;
   end

   // stage 2: gregorian leap rule and the serial sum
   assign rem_zero = (s1_date_ff.year == YEAR_W'(YEAR_W'(s1_qyr_ff) * CENTURY));
   assign leap     = (s1_date_ff.year[1:0] == 2'b00 && !rem_zero)
                     || (rem_zero && s1_qyr_ff[1:0] == 2'b00);

   assign sum = SUM_W'(s1_y1_ff) * DAYS_PER_YEAR
                + SUM_W'(s1_y1_ff >> 2)
                - SUM_W'(s1_qy1_ff)
                + SUM_W'(s1_qy1_ff >> 2)
                + SUM_W'(days_before(s1_date_ff.month))
                + SUM_W'(leap && s1_date_ff.month > MONTH_W'(2))
                + SUM_W'(s1_date_ff.day);

   always_comb begin
      s2_item_in.date   = s1_date_ff;
      s2_item_in.last   = s1_last_ff;
      s2_item_in.serial = (sum > SUM_W'(SERIAL_MAX)) ? SERIAL_MAX : sum[SERIAL_W-1:0];
   end

   assign item_push = s2_valid_ff;
   assign item      = s2_item_ff;

endmodule

@@ rtl/core/fdp_queue.sv @@
module fdp_queue
   import fdp_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   localparam int LW = $clog2(QUEUE_DEPTH + 1),
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  fdp_item_type  push_item,
   input  logic          pop,
   output logic          empty,
   output fdp_item_type  head,
   output logic [LW-1:0] level
);

   fdp_item_type  slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0] level_ff, level_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         level_in = level_ff + LW'(1);
      end else if (pop && !push) begin
         level_in = level_ff - LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign empty = (level_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];
   assign level = level_ff;

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (level_ff < LW'(QUEUE_DEPTH) || pop))
      else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> level_ff != '0)
      else $error("queue underflow");
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LW'(QUEUE_DEPTH))
      else $error("queue level out of range");
`endif

endmodule

@@ rtl/core/fdp_back.sv @@
module fdp_back
   import fdp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           queue_empty,
   input  fdp_item_type   head,
   output logic           queue_pop,
   output logic           rsp_empty,
   input  logic           rsp_pop,
   output fdp_result_type result
);

   logic                started_ff, started_in;
   logic                seen_first_ff, seen_first_in;
   logic [SERIAL_W-1:0] earliest_ff, earliest_in;
   logic [SERIAL_W-1:0] latest_ff, latest_in;
   fdp_date_type        early_date_ff, early_date_in;
   fdp_date_type        late_date_ff, late_date_in;
   logic                out_valid_ff, out_valid_in;
   fdp_result_type      result_ff, result_in;
   logic                take, lower, upper;

   // a last item needs the result slot free or leaving
   assign take      = !queue_empty && (!head.last || !out_valid_ff || rsp_pop);
   assign queue_pop = take;

   assign lower = !started_ff || head.serial < earliest_ff;
   assign upper = !started_ff || head.serial > latest_ff;

   always_comb begin
      earliest_in   = lower ? head.serial : earliest_ff;
      early_date_in = lower ? head.date : early_date_ff;
      latest_in     = upper ? head.serial : latest_ff;
      late_date_in  = upper ? head.date : late_date_ff;
      seen_first_in = seen_first_ff;
      if (upper) begin
         seen_first_in = 1'b1;
      end else if (lower) begin
         seen_first_in = 1'b0;
      end
      started_in = !head.last;

      result_in.distance = latest_in - earliest_in;
      if (earliest_in == latest_in) begin
         result_in.first  = early_date_in;
         result_in.second = early_date_in;
      end else if (seen_first_in) begin
         result_in.first  = early_date_in;
         result_in.second = late_date_in;
      end else begin
         result_in.first  = late_date_in;
         result_in.second = early_date_in;
      end

      out_valid_in = out_valid_ff;
      if (take && head.last) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            started_ff <= started_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         earliest_ff   <= earliest_in;
         latest_ff     <= latest_in;
         early_date_ff <= early_date_in;
         late_date_ff  <= late_date_in;
         seen_first_ff <= seen_first_in;
      end
      if (take && head.last) begin
         result_ff <= result_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign result    = result_ff;

`ifndef NO_ASSERTIONS
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_pop |=> out_valid_ff && $stable(result_ff))
      else $error("waiting result lost or changed");
   a_extremes_ordered: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> earliest_ff <= latest_ff)
      else $error("earliest serial above latest");
   a_set_closed: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> !started_ff)
      else $error("set still open after its result");
`endif

endmodule

@@ rtl/core/farthest_date_pair.sv @@
// farthest_date_pair: farthest-apart pair of gregorian dates in a stream
// request channel: a date (day, month, year) and a last mark, taken when
//    req_push is high and req_full is low; one request a cycle is accepted
// response channel: one response per set, on the request marked last; it is
//    shown while rsp_empty is low and taken when rsp_pop is high
// the response gives the extreme date seen first, then the other extreme,
//    and their distance in days; equal dates give the first date twice
// a last request passes the two front stages and the queue; its response is registered in the back end
// throughput: one request a cycle while req_full is low, set by the two-stage
//    serial day pipeline and the single compare-and-update step in the back end
// a queue of QUEUE_DEPTH entries parts the front end from the back end;
//    req_full rises when the queue and the front pipeline hold that many
// a stalled response holds; requests keep flowing until the queue fills
// reset clears the pipeline, the queue and any open set
module farthest_date_pair
   import fdp_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_push,
   output logic                req_full,
   input  logic [DAY_W-1:0]    req_day,
   input  logic [MONTH_W-1:0]  req_month,
   input  logic [YEAR_W-1:0]   req_year,
   input  logic                req_last,
   // response channel
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [DAY_W-1:0]    rsp_first_day,
   output logic [MONTH_W-1:0]  rsp_first_month,
   output logic [YEAR_W-1:0]   rsp_first_year,
   output logic [DAY_W-1:0]    rsp_second_day,
   output logic [MONTH_W-1:0]  rsp_second_month,
   output logic [YEAR_W-1:0]   rsp_second_year,
   output logic [SERIAL_W-1:0] rsp_distance_days
);

   localparam int LW = $clog2(QUEUE_DEPTH + 1);

   logic           item_push;
   fdp_item_type   item;
   logic [LW-1:0]  queue_level;
   logic           queue_empty;
   logic           queue_pop;
   fdp_item_type   head;
   fdp_result_type result;

   // front end: serial day number, two register stages
   fdp_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_day     (req_day),
      .req_month   (req_month),
      .req_year    (req_year),
      .req_last    (req_last),
      .queue_level (queue_level),
      .item_push   (item_push),
      .item        (item)
   );

   // decoupling queue
   fdp_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (item_push),
      .push_item (item),
      .pop       (queue_pop),
      .empty     (queue_empty),
      .head      (head),
      .level     (queue_level)
   );

   // back end: running extremes and the response register
   fdp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .queue_pop   (queue_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .result      (result)
   );

   assign rsp_first_day     = result.first.day;
   assign rsp_first_month   = result.first.month;
   assign rsp_first_year    = result.first.year;
   assign rsp_second_day    = result.second.day;
   assign rsp_second_month  = result.second.month;
   assign rsp_second_year   = result.second.year;
   assign rsp_distance_days = result.distance;

endmodule
